// ----- hw/rtl/tridiagonal_power_iteration_assert.svh -----
// assertion macros for the power iteration block
`ifndef TRIDIAGONAL_POWER_ITERATION_ASSERT_SVH
`define TRIDIAGONAL_POWER_ITERATION_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpi assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define TPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpi assertion failed");

`endif

// ----- hw/rtl/tpi_pkg.sv -----
// shared types and constants of the power iteration block
package tpi_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DIAG   = 2'd0;
  localparam logic [1:0] CFG_OFFD   = 2'd1;
  localparam logic [1:0] CFG_EPOCHS = 2'd2;

  // arithmetic widths
  localparam int unsigned ACC_W      = 72;  // sum of squares, Q.48
  localparam int unsigned ROOT_W     = 36;  // integer root, Q.24
  localparam int unsigned REM_W      = 40;  // partial remainder
  localparam int unsigned NUM_W      = 63;  // rounded dividend
  localparam int unsigned STEP_W     = 6;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd36;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd31;

  // command to the root and divide unit
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } tpi_cmd_t;

  // status from the root and divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } tpi_sts_t;

endpackage

// ----- hw/rtl/tridiagonal_power_iteration.sv -----
// power iteration on a tridiagonal toeplitz matrix: top level
// load: one start element per cycle; fill writes zero to each unloaded element
// epoch: the shared multiplier walk over x, then the 36-step root and one 31-step
// divide per element in the shared unit
// first norm after any fill, the multiplier walk over x and the root
// reset clears control and loads configuration defaults; vector memories hold no reset value
module tridiagonal_power_iteration
  import tpi_pkg::*;
#(
  parameter int unsigned VECTOR_LENGTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // start_element[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // norm_value[31:0], epoch_index[37:32], zero pad
  output logic [0:0]  m_axis_tuser,   // zero_vector_error[0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned POS_W = $clog2(VECTOR_LENGTH + 1);
  localparam logic [POS_W-1:0] LEN   = POS_W'(VECTOR_LENGTH);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(VECTOR_LENGTH - 1);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_EPST  = 4'd2;
  localparam logic [3:0] ST_EPLD  = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_MA    = 4'd5;
  localparam logic [3:0] ST_MB    = 4'd6;
  localparam logic [3:0] ST_MC    = 4'd7;
  localparam logic [3:0] ST_MD    = 4'd8;
  localparam logic [3:0] ST_ME    = 4'd9;
  localparam logic [3:0] ST_SQRT  = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;
  localparam logic [3:0] ST_DVRD  = 4'd12;
  localparam logic [3:0] ST_DVGO  = 4'd13;
  localparam logic [3:0] ST_DVWT  = 4'd14;

  // configuration
  logic signed [15:0] diag_q, offd_q;
  logic [6:0]         epochs_cfg_q, epochs_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q       <= 16'sd8192;
      offd_q       <= -16'sd4096;
      epochs_cfg_q <= 7'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIAG:   diag_q       <= cfg_data_i;
        CFG_OFFD:   offd_q       <= cfg_data_i;
        CFG_EPOCHS: epochs_cfg_q <= cfg_data_i[6:0];
        default:    ;
      endcase
    end
  end

  // clamp the epoch count to 1..64
  always_comb begin
    priority if (epochs_cfg_q == 7'd0) epochs_eff = 7'd1;
    else if (epochs_cfg_q > 7'd64)     epochs_eff = 7'd64;
    else                               epochs_eff = epochs_cfg_q;
  end

  logic [3:0]         state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [5:0]         epoch_q, epoch_d;
  logic signed [31:0] xprev_q, xprev_d, xcur_q, xcur_d, y_q, y_d;
  logic signed [32:0] nb_q, nb_d;
  logic signed [65:0] mul_q, p1_q, p1_d;
  logic signed [32:0] mul_a, mul_b;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic               sign_q, sign_d;
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d, out_err_q, out_err_d;
  logic [31:0]        out_norm_q, out_norm_d;
  logic [5:0]         out_epoch_q, out_epoch_d;

  // vector memories
  logic signed [31:0] xmem [VECTOR_LENGTH];
  logic signed [31:0] ymem [VECTOR_LENGTH];
  logic               xwe, ywe;
  logic [IDX_W-1:0]   xwaddr, xraddr, yraddr;
  logic signed [31:0] xwdata, xrdata_q, yrdata_q;

  always_ff @(posedge clk_i) begin
    if (xwe) xmem[xwaddr] <= xwdata;
    if (ywe) ymem[idx_q] <= y_d;
    xrdata_q <= xmem[xraddr];
    yrdata_q <= ymem[yraddr];
  end

  // shared multiplier
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // root and divide unit
  tpi_cmd_t          cmd;
  tpi_sts_t          sts;
  logic [ROOT_W-1:0] unit_res;
  logic [NUM_W-1:0]  dividend;
  logic [31:0]       ymag;

  // the root starts on the sum that includes the last square
  tpi_root_div u_root_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .radicand_i (acc_d),
    .dividend_i (dividend),
    .divisor_i  (root_q),
    .sts_o      (sts),
    .result_o   (unit_res)
  );

  assign ymag     = yrdata_q[31] ? 32'(-yrdata_q) : yrdata_q;
  assign dividend = {1'b0, ymag, 30'd0} + {{(NUM_W-ROOT_W+1){1'b0}}, root_q[ROOT_W-1:1]};

  logic               in_beat, out_free, has_next, ep_last;
  logic signed [49:0] vsum, vrnd;
  logic [30:0]        q31;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign has_next = idx_q != LAST_I;
  assign ep_last  = ({1'b0, epoch_q} + 7'd1) == epochs_eff;
  assign vsum     = $signed(p1_q[49:0]) + $signed(mul_q[49:0]);
  assign vrnd     = vsum + 50'sd131072;
  assign q31      = unit_res[30:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    epoch_d     = epoch_q;
    xprev_d     = xprev_q;
    xcur_d      = xcur_q;
    nb_d        = nb_q;
    p1_d        = p1_q;
    y_d         = y_q;
    acc_d       = acc_q;
    root_d      = root_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    out_norm_d  = out_norm_q;
    out_epoch_d = out_epoch_q;
    mul_a       = 33'(diag_q);
    mul_b       = 33'(xcur_q);
    xwe         = 1'b0;
    xwaddr      = pos_q[IDX_W-1:0];
    xwdata      = s_axis_tdata;
    xraddr      = IDX_W'(idx_q + 1'b1);
    yraddr      = idx_q;
    ywe         = 1'b0;
    cmd         = '{start_sqrt: 1'b0, start_div: 1'b0};
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (pos_q < LEN) begin
            xwe   = 1'b1;
            pos_d = pos_q + 1'b1;
          end
          if (s_axis_tlast) state_d = (pos_d < LEN) ? ST_FILL : ST_EPST;
        end
      end
      ST_FILL: begin
        xwe    = 1'b1;
        xwdata = '0;
        pos_d  = pos_q + 1'b1;
        if (pos_d == LEN) state_d = ST_EPST;
      end
      ST_EPST: begin
        xraddr  = '0;
        state_d = ST_EPLD;
      end
      ST_EPLD: begin
        xcur_d  = xrdata_q;
        xprev_d = '0;
        acc_d   = '0;
        idx_d   = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_MA;
      end
      ST_MA: begin
        nb_d    = 33'(xprev_q) + 33'(has_next ? xrdata_q : 32'sd0);
        xprev_d = xcur_q;
        xcur_d  = has_next ? xrdata_q : 32'sd0;
        state_d = ST_MB;
      end
      ST_MB: begin
        p1_d    = mul_q;
        mul_a   = 33'(offd_q);
        mul_b   = nb_q;
        state_d = ST_MC;
      end
      ST_MC: begin
        y_d     = vrnd[49:18];
        ywe     = 1'b1;
        state_d = ST_MD;
      end
      ST_MD: begin
        mul_a   = 33'(y_q);
        mul_b   = 33'(y_q);
        state_d = ST_ME;
      end
      ST_ME: begin
        acc_d = acc_q + {{(ACC_W-62){1'b0}}, mul_q[61:0]};
        if (has_next) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_RD;
        end else begin
          cmd.start_sqrt = 1'b1;
          state_d        = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.done) begin
          root_d  = unit_res;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_epoch_d = epoch_q;
          out_norm_d  = (|root_q[ROOT_W-1:32]) ? 32'hFFFF_FFFF : root_q[31:0];
          out_err_d   = root_q == '0;
          out_last_d  = ep_last || (root_q == '0);
          idx_d       = '0;
          if (ep_last || root_q == '0) begin
            pos_d   = '0;
            epoch_d = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DVRD;
          end
        end
      end
      ST_DVRD: begin
        state_d = ST_DVGO;
      end
      ST_DVGO: begin
        sign_d        = yrdata_q[31];
        cmd.start_div = 1'b1;
        state_d       = ST_DVWT;
      end
      ST_DVWT: begin
        if (sts.done) begin
          xwe    = 1'b1;
          xwaddr = idx_q;
          xwdata = sign_q ? -$signed({1'b0, q31}) : $signed({1'b0, q31});
          if (has_next) begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DVRD;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = ST_EPST;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      idx_q       <= '0;
      epoch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xprev_q     <= xprev_d;
    xcur_q      <= xcur_d;
    nb_q        <= nb_d;
    p1_q        <= p1_d;
    y_q         <= y_d;
    acc_q       <= acc_d;
    root_q      <= root_d;
    sign_q      <= sign_d;
    out_last_q  <= out_last_d;
    out_err_q   <= out_err_d;
    out_norm_q  <= out_norm_d;
    out_epoch_q <= out_epoch_d;
  end

  // ports
  assign s_axis_tready = state_q == ST_LOAD;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_epoch_q, out_norm_q};
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  `include "tridiagonal_power_iteration_assert.svh"

  `TPI_ASSERT_IMP(a_err_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
  `TPI_ASSERT_IMP(a_err_zero_norm, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0)
  `TPI_ASSERT_IMP(a_no_start_busy, cmd.start_sqrt || cmd.start_div, !sts.busy)
  `TPI_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= LEN)
  `TPI_ASSERT_NXT(a_run_leaves_load, in_beat && s_axis_tlast, !s_axis_tready)

endmodule

// ----- hw/rtl/tpi_root_div.sv -----
// shared bit-serial unit: integer square root and restoring division
module tpi_root_div
  import tpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpi_cmd_t          cmd_i,
  input  logic [ACC_W-1:0]  radicand_i,
  input  logic [NUM_W-1:0]  dividend_i,
  input  logic [ROOT_W-1:0] divisor_i,
  output tpi_sts_t          sts_o,
  output logic [ROOT_W-1:0] result_o
);

  logic              busy_q, busy_d, done_q, done_d, sqrt_q, sqrt_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] res_q, res_d, div_q, div_d;
  logic [ACC_W-1:0]  opnd_q, opnd_d;
  logic [REM_W-1:0]  remx, trial, diff;
  logic              ge;

  // one compare and subtract per cycle
  always_comb begin
    if (sqrt_q) begin
      remx  = {rem_q[REM_W-3:0], opnd_q[ACC_W-1 -: 2]};
      trial = {2'b00, res_q, 2'b01};
    end else begin
      remx  = {rem_q[REM_W-2:0], opnd_q[ACC_W-1]};
      trial = {{(REM_W-ROOT_W){1'b0}}, div_q};
    end
    ge   = remx >= trial;
    diff = remx - trial;
  end

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    opnd_d = opnd_q;
    if (cmd_i.start_sqrt) begin
      busy_d = 1'b1;
      sqrt_d = 1'b1;
      cnt_d  = SQRT_STEPS;
      rem_d  = '0;
      res_d  = '0;
      opnd_d = radicand_i;
    end else if (cmd_i.start_div) begin
      busy_d = 1'b1;
      sqrt_d = 1'b0;
      cnt_d  = DIV_STEPS;
      rem_d  = {{(REM_W-32){1'b0}}, dividend_i[NUM_W-1:31]};
      res_d  = '0;
      div_d  = divisor_i;
      opnd_d = {dividend_i[30:0], {(ACC_W-31){1'b0}}};
    end else if (busy_q) begin
      rem_d  = ge ? diff : remx;
      res_d  = {res_q[ROOT_W-2:0], ge};
      opnd_d = sqrt_q ? {opnd_q[ACC_W-3:0], 2'b00} : {opnd_q[ACC_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    res_q  <= res_d;
    div_q  <= div_d;
    opnd_q <= opnd_d;
  end

  assign sts_o    = '{busy: busy_q, done: done_q};
  assign result_o = res_q;

endmodule
